// ===== sv/psm_pkg.sv =====
package psm_pkg;

  localparam int DefSources    = 4;
  localparam int DefQueueDepth = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSH_OK    = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_OK     = 2'd2,
    ST_POP_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] ev_time;
    logic [63:0] ev_seq;
    logic [7:0]  ev_kind;
    logic [63:0] ev_payload;
  } event_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic       pop;
    logic       bad_src;
    logic [1:0] src;
    event_t     ev;
  } cmd_t;

endpackage

// ===== sv/psm_if.sv =====
interface psm_evt_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] event_time;
  logic [1:0]  source_id;
  logic [63:0] event_seq;
  logic [7:0]  event_kind;
  logic [63:0] event_payload;

  modport source (
    output valid, opcode, event_time, source_id, event_seq, event_kind, event_payload,
    input  ready
  );
  modport sink (
    input  valid, opcode, event_time, source_id, event_seq, event_kind, event_payload,
    output ready
  );
endinterface

interface psm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_time;
  logic [1:0]  out_source;
  logic [63:0] out_seq;
  logic [7:0]  out_kind;
  logic [63:0] out_payload;
  logic [6:0]  total_queued;

  modport source (
    output valid, status, out_time, out_source, out_seq, out_kind, out_payload,
           total_queued,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_source, out_seq, out_kind, out_payload,
           total_queued,
    output ready
  );
endinterface

// ===== sv/psm_front.sv =====
module psm_front #(
  parameter int SOURCES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  psm_evt_if.sink        evt_i,
  output psm_pkg::cmd_t  cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import psm_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.pop            = (evt_i.opcode == OP_POP);
    cmd_new.bad_src        = (32'(evt_i.source_id) >= SOURCES);
    cmd_new.src            = evt_i.source_id;
    cmd_new.ev.ev_time     = evt_i.event_time;
    cmd_new.ev.ev_seq      = evt_i.event_seq;
    cmd_new.ev.ev_kind     = evt_i.event_kind;
    cmd_new.ev.ev_payload  = evt_i.event_payload;
  end

  assign evt_i.ready = (cnt_q != 2'd2);
  assign push        = evt_i.valid && evt_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_new;
  end

endmodule

// ===== sv/psm_back.sv =====
module psm_back #(
  parameter int SOURCES     = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psm_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  psm_res_if.source      res_o
);
  import psm_pkg::*;

  localparam int SrcW  = $clog2(SOURCES);
  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int Slots = SOURCES * QUEUE_DEPTH;
  localparam int SlotW = $clog2(Slots);
  localparam int TotW  = $clog2(Slots + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  event_t          mem [Slots];
  event_t          rd_q;
  event_t          cache_q [SOURCES];
  logic [PtrW-1:0] head_q [SOURCES];
  logic [PtrW-1:0] tail_q [SOURCES];
  logic [CntW-1:0] fill_q [SOURCES];
  logic [TotW-1:0] total_q;
  logic [1:0]      state_q;
  logic [SrcW-1:0] cur_q, best_q;
  logic            have_q;

  logic            out_valid_q;
  status_e         status_q;
  event_t          out_ev_q;
  logic [1:0]      out_src_q;
  logic [TotW-1:0] out_tot_q;

  logic            out_free, start, push_fire, empty_fire, scan_start, take_fire;
  logic            push_ok, reload, cand;
  logic [SrcW-1:0] src_ix;
  logic [PtrW-1:0] new_head;
  logic [SlotW-1:0] wr_addr, rd_addr;

  always_comb begin
    out_free   = !out_valid_q || res_o.ready;
    start      = (state_q == ST_IDLE) && cmd_valid_i && out_free;
    src_ix     = SrcW'(cmd_i.src);
    push_ok    = !cmd_i.bad_src && (fill_q[src_ix] != CntW'(QUEUE_DEPTH));
    push_fire  = start && !cmd_i.pop;
    empty_fire = start && cmd_i.pop && (total_q == '0);
    scan_start = start && cmd_i.pop && (total_q != '0);
    take_fire  = (state_q == ST_TAKE) && out_free;
    cmd_ready_o = push_fire || empty_fire || take_fire;
    new_head   = next_slot(head_q[best_q]);
    reload     = take_fire && (fill_q[best_q] != CntW'(1));
    wr_addr    = SlotW'(int'(src_ix) * QUEUE_DEPTH + int'(tail_q[src_ix]));
    rd_addr    = SlotW'(int'(best_q) * QUEUE_DEPTH + int'(new_head));
    // later sources win only on a strictly earlier timestamp
    cand       = (fill_q[cur_q] != '0) &&
                 (!have_q || (cache_q[cur_q].ev_time < cache_q[best_q].ev_time));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SOURCES; s++) begin
        head_q[s] <= '0;
        tail_q[s] <= '0;
        fill_q[s] <= '0;
      end
      total_q     <= '0;
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      best_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_ready_o) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (push_fire && push_ok) begin
            tail_q[src_ix] <= next_slot(tail_q[src_ix]);
            fill_q[src_ix] <= fill_q[src_ix] + CntW'(1);
            total_q        <= total_q + TotW'(1);
          end
          if (scan_start) begin
            cur_q   <= '0;
            have_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cand) begin
            best_q <= cur_q;
            have_q <= 1'b1;
          end
          if (cur_q == SrcW'(SOURCES - 1)) state_q <= ST_TAKE;
          else cur_q <= cur_q + SrcW'(1);
        end
        ST_TAKE: begin
          if (take_fire) begin
            head_q[best_q] <= new_head;
            fill_q[best_q] <= fill_q[best_q] - CntW'(1);
            total_q        <= total_q - TotW'(1);
            state_q        <= reload ? ST_LOAD : ST_IDLE;
          end
        end
        ST_LOAD: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire && push_ok) begin
      mem[wr_addr] <= cmd_i.ev;
      if (fill_q[src_ix] == '0) cache_q[src_ix] <= cmd_i.ev;
    end
    rd_q <= mem[rd_addr];
    // refill the head copy of the source just popped
    if (state_q == ST_LOAD) cache_q[best_q] <= rd_q;
    if (push_fire) begin
      status_q  <= push_ok ? ST_PUSH_OK : ST_PUSH_FULL;
      out_ev_q  <= '0;
      out_src_q <= '0;
      out_tot_q <= push_ok ? total_q + TotW'(1) : total_q;
    end else if (empty_fire) begin
      status_q  <= ST_POP_EMPTY;
      out_ev_q  <= '0;
      out_src_q <= '0;
      out_tot_q <= total_q;
    end else if (take_fire) begin
      status_q  <= ST_POP_OK;
      out_ev_q  <= cache_q[best_q];
      out_src_q <= 2'(best_q);
      out_tot_q <= total_q - TotW'(1);
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = status_q;
  assign res_o.out_time     = out_ev_q.ev_time;
  assign res_o.out_source   = out_src_q;
  assign res_o.out_seq      = out_ev_q.ev_seq;
  assign res_o.out_kind     = out_ev_q.ev_kind;
  assign res_o.out_payload  = out_ev_q.ev_payload;
  assign res_o.total_queued = 7'(out_tot_q);

endmodule

// ===== sv/per_source_fifo_ordered_merge_core.sv =====
// Channel | Dir | Modport | Carries
// evt_i   | in  | sink    | push or pop command with one event
// res_o   | out | source  | status, popped event, total queued
//
// Push: handled in the back end once the result register is free.
// Pop: a start step, a scan of the head copies one source at a time with one
// 64-bit compare, a deliver step, plus a refill of the head copy
// from the slot memory (registered read port) when the FIFO stays non-empty.
// A two-entry command queue lets input accept while the back end works;
// the result register holds until taken. Reset clears pointers and counts.
module per_source_fifo_ordered_merge_core #(
  parameter int SOURCES     = psm_pkg::DefSources,
  parameter int QUEUE_DEPTH = psm_pkg::DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psm_evt_if.sink   evt_i,
  psm_res_if.source res_o
);
  import psm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  psm_front #(
    .SOURCES (SOURCES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  psm_back #(
    .SOURCES     (SOURCES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_no_empty_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> cmd_valid) else $error("back end took from an empty queue");

  a_empty_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == ST_POP_EMPTY) |-> (res_o.total_queued == 7'd0))
    else $error("empty pop with events queued");

  a_pop_shows_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_ready && cmd.pop && !$past(cmd_ready)) |=> (res_o.status == ST_POP_OK ||
    res_o.status == ST_POP_EMPTY)) else $error("pop transaction gave a push status");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import psm_pkg::*;

  localparam int NSRC  = DefSources;
  localparam int DEPTH = DefQueueDepth;

  typedef struct packed {
    logic        op;
    logic [63:0] t;
    logic [1:0]  src;
    logic [63:0] seq;
    logic [7:0]  kind;
    logic [63:0] pay;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] t;
    logic [1:0]  src;
    logic [63:0] seq;
    logic [7:0]  kind;
    logic [63:0] pay;
    logic [6:0]  total;
  } merge_res_t;

  logic clk_i;
  logic rst_ni;

  psm_evt_if evt_if ();
  psm_res_if res_if ();

  per_source_fifo_ordered_merge_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if.sink),
    .res_o  (res_if.source)
  );

  // model state: one queue of events per source
  event_t     mdl_fifo[NSRC][$];
  int         mdl_total;

  cmd_item_t  pending_cmds[$];
  merge_res_t expected_res[$];

  int  mismatches;
  bit  in_fire;       // input transaction taken at the last rising edge
  bit  calm;          // no idling on either side
  int  hold_cycles;   // long receiver hold-off

  function automatic bit head_less(event_t a, int sa, event_t b, int sb);
    if (a.ev_time != b.ev_time) return a.ev_time < b.ev_time;
    if (sa != sb) return sa < sb;
    if (a.ev_seq != b.ev_seq) return a.ev_seq < b.ev_seq;
    return a.ev_kind < b.ev_kind;
  endfunction

  function automatic merge_res_t merge_predict(cmd_item_t c);
    merge_res_t r;
    event_t     e;
    int         best;
    r = '0;
    if (c.op == OP_PUSH) begin
      if (int'(c.src) >= NSRC || mdl_fifo[c.src].size() >= DEPTH) begin
        r.status = ST_PUSH_FULL;
      end else begin
        e.ev_time = c.t;
        e.ev_seq = c.seq;
        e.ev_kind = c.kind;
        e.ev_payload = c.pay;
        mdl_fifo[c.src].insert(mdl_fifo[c.src].size(), e);
        mdl_total++;
        r.status = ST_PUSH_OK;
      end
    end else begin
      best = -1;
      for (int s = 0; s < NSRC; s++) begin
        if (mdl_fifo[s].size() == 0) continue;
        if (best < 0 || head_less(mdl_fifo[s][0], s, mdl_fifo[best][0], best)) best = s;
      end
      if (best < 0) begin
        r.status = ST_POP_EMPTY;
      end else begin
        e = mdl_fifo[best][0];
        mdl_fifo[best].delete(0);
        mdl_total--;
        r.status = ST_POP_OK;
        r.t = e.ev_time;
        r.src = best[1:0];
        r.seq = e.ev_seq;
        r.kind = e.ev_kind;
        r.pay = e.ev_payload;
      end
    end
    r.total = mdl_total[6:0];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_cmd(logic op, logic [63:0] t, logic [1:0] src, logic [63:0] seq,
                         logic [7:0] kind, logic [63:0] pay);
    cmd_item_t c;
    c.op = op;
    c.t = t;
    c.src = src;
    c.seq = seq;
    c.kind = kind;
    c.pay = pay;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: change at falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
      {evt_if.opcode, evt_if.event_time, evt_if.source_id, evt_if.event_seq,
       evt_if.event_kind, evt_if.event_payload} <= '0;
    end else if (!evt_if.valid || in_fire) begin
      // drop the transaction taken at the last rising edge
      if (in_fire) pending_cmds.delete(0);
      if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        evt_if.valid <= 1'b1;
        {evt_if.opcode, evt_if.event_time, evt_if.source_id, evt_if.event_seq,
         evt_if.event_kind, evt_if.event_payload} <= pending_cmds[0];
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  // acceptance is seen at the rising edge; predict there
  always @(posedge clk_i) begin
    in_fire = rst_ni && evt_if.valid && evt_if.ready;
    if (in_fire) begin
      expected_res.insert(expected_res.size(), merge_predict({evt_if.opcode,
        evt_if.event_time, evt_if.source_id, evt_if.event_seq, evt_if.event_kind,
        evt_if.event_payload}));
    end
  end

  // receiver ready, changed at falling edge
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    merge_res_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.status, res_if.out_time, res_if.out_source, res_if.out_seq,
             res_if.out_kind, res_if.out_payload, res_if.total_queued};
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_res[0];
        expected_res.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: status %0d/%0d time %h/%h src %0d/%0d",
                     want.status, got.status, want.t, got.t, want.src, got.src);
            $display("  seq %h/%h kind %h/%h pay %h/%h total %0d/%0d",
                     want.seq, got.seq, want.kind, got.kind, want.pay, got.pay,
                     want.total, got.total);
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int n;
    logic [63:0] tb;
    rst_ni = 1'b0;
    calm = 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    in_fire = 1'b0;
    mdl_total = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pop, extremes, ties on time, full FIFO
    add_cmd(OP_POP, '1, 2'd3, '1, 8'hff, '1);
    add_cmd(OP_PUSH, '1, 2'd3, '1, 8'hff, '1);
    add_cmd(OP_PUSH, '0, 2'd0, '0, 8'h00, '0);
    add_cmd(OP_PUSH, 64'd5, 2'd2, 64'd1, 8'h10, 64'h1234);
    add_cmd(OP_PUSH, 64'd5, 2'd1, 64'd9, 8'h01, 64'h5678);
    for (int i = 0; i < 6; i++)
      add_cmd(OP_POP, rand64(), 2'($urandom), rand64(), 8'($urandom), rand64());
    for (int i = 0; i < DEPTH + 2; i++)
      add_cmd(OP_PUSH, 64'd100 - 64'(i), 2'd1, 64'(i), 8'(i), rand64());
    wait (pending_cmds.size() == 0);

    // keep the receiver off while the sender fills the block
    @(negedge clk_i);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++)
      add_cmd($urandom_range(0, 3) == 0, rand64(), 2'($urandom), rand64(), 8'($urandom), rand64());

    // random: bursts of pushes with small times for ties, or bursts of pops
    n = 0;
    while (n < 1400) begin
      if (n > 500 && n < 800) calm = 1'b1; else calm = 1'b0;
      tb = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 20));
      if ($urandom_range(0, 1)) begin
        for (int k = 0; k < $urandom_range(1, 30); k++) begin
          add_cmd(OP_PUSH, ($urandom_range(0, 1) ? tb : rand64()), 2'($urandom),
                  rand64(), 8'($urandom), rand64());
          n++;
        end
      end else begin
        for (int k = 0; k < $urandom_range(1, 30); k++) begin
          add_cmd(OP_POP, rand64(), 2'($urandom), rand64(), 8'($urandom), rand64());
          n++;
        end
      end
      wait (pending_cmds.size() < 20);
    end
    wait (pending_cmds.size() == 0);
    wait (expected_res.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
